// File: design/cptr_pkg.sv
// Shared types and constants of the capture-period tachometer.
package cptr_pkg;

  localparam int unsigned CaptW       = 16;
  localparam int unsigned ReloadW     = 16;
  localparam int unsigned PeriodW     = 17;
  localparam int unsigned RpmW        = 16;
  localparam int unsigned WheelW      = 2;
  localparam int unsigned MaxWheels   = 4;
  localparam int unsigned FrameW      = RpmW * MaxWheels;
  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned CfgDataW    = ReloadW;

  localparam int unsigned DefWheelCount = 4;
  localparam int unsigned DefRpmScale   = 15;
  localparam int unsigned DefQueueDepth = 2;

  // Register index of the first reload register; wheel w sits at base + w
  localparam logic [CfgIdxW-1:0] REG_RELOAD_BASE = 4'd0;

  localparam logic [ReloadW-1:0] ReloadResetVal = 16'hFFFF;

  typedef enum logic [1:0] {
    RF_OK   = 2'd0,
    RF_SAT  = 2'd1,
    RF_ZERO = 2'd2
  } range_flag_e;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic [WheelW-1:0]  wheel;
    logic [ReloadW-1:0] reload;
    logic [PeriodW-1:0] period;
  } job_t;

endpackage

// File: design/cptr_front.sv
// Front end: reload registers, item intake and wrap-corrected period.
module cptr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cptr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cptr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cptr_pkg::WheelW-1:0]   wheel_i,
  input  logic [cptr_pkg::CaptW-1:0]    first_i,
  input  logic [cptr_pkg::CaptW-1:0]    second_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output cptr_pkg::job_t                job_o
);
  import cptr_pkg::*;

  logic [ReloadW-1:0] reload_q [MaxWheels];
  logic [ReloadW-1:0] reload;
  logic [PeriodW-1:0] wrap_sum;
  logic [PeriodW-1:0] period;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < MaxWheels; w++) begin
        reload_q[w] <= ReloadResetVal;
      end
    end else if (cfg_we_i) begin
      // drop writes to indexes beyond the register list
      for (int w = 0; w < MaxWheels; w++) begin
        if (cfg_index_i == REG_RELOAD_BASE + CfgIdxW'(w)) begin
          reload_q[w] <= cfg_data_i;
        end
      end
    end
  end

  assign reload   = reload_q[wheel_i];
  assign wrap_sum = {1'b0, reload} + {1'b0, second_i};

  always_comb begin
    if (first_i > second_i) begin
      // counter wrapped between the captures; clamp if captures exceed reload
      if (wrap_sum >= {1'b0, first_i}) begin
        period = wrap_sum - {1'b0, first_i};
      end else begin
        period = '0;
      end
    end else begin
      period = {1'b0, second_i - first_i};
    end
  end

  assign in_ready_o    = job_ready_i;
  assign job_valid_o   = in_valid_i;
  assign job_o.wheel   = wheel_i;
  assign job_o.reload  = reload;
  assign job_o.period  = period;

endmodule

// File: design/cptr_queue.sv
// Short flop-based queue of classified items between front and back.
module cptr_queue #(
  parameter int unsigned DEPTH = cptr_pkg::DefQueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  cptr_pkg::job_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output cptr_pkg::job_t pop_data_o
);
  import cptr_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    if (p == PtrW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// File: design/cptr_back.sv
// Back end: iterative divider, scaling with saturation, speed store, result register.
module cptr_back #(
  parameter int unsigned WHEEL_COUNT = cptr_pkg::DefWheelCount,
  parameter int unsigned RPM_SCALE   = cptr_pkg::DefRpmScale
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  output logic                         job_ready_o,
  input  cptr_pkg::job_t               job_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cptr_pkg::WheelW-1:0]  wheel_id_o,
  output logic [cptr_pkg::PeriodW-1:0] period_o,
  output logic [cptr_pkg::RpmW-1:0]    rpm_o,
  output logic [cptr_pkg::FrameW-1:0]  frame_o,
  output cptr_pkg::range_flag_e        flag_o
);
  import cptr_pkg::*;

  localparam int unsigned ScaleW = $clog2(RPM_SCALE + 1);
  localparam int unsigned ProdW  = ReloadW + ScaleW;
  localparam int unsigned StepW  = $clog2(ReloadW);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SCALE,
    S_OUT
  } state_e;

  state_e             state_q;
  job_t               job_q;
  logic [PeriodW-1:0] rem_q;
  logic [ReloadW-1:0] quo_q;
  logic [StepW-1:0]   step_q;
  logic [ProdW-1:0]   prod_q;
  logic               zero_q;
  logic               out_valid_q;
  logic [WheelW-1:0]  wheel_id_q;
  logic [PeriodW-1:0] period_q;
  logic [RpmW-1:0]    rpm_q;
  logic [FrameW-1:0]  frame_q;
  range_flag_e        flag_q;
  logic [RpmW-1:0]    store_q [WHEEL_COUNT];

  logic [PeriodW:0]   trial;
  logic               fits;
  logic               load_out;
  range_flag_e        flag_d;
  logic [RpmW-1:0]    rpm_d;
  logic [RpmW-1:0]    store_d [WHEEL_COUNT];
  logic [FrameW-1:0]  frame_d;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[ReloadW-1]};
  assign fits  = (trial >= {1'b0, job_q.period});

  assign load_out    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign job_ready_o = (state_q == S_IDLE);

  always_comb begin
    if (zero_q) begin
      flag_d = RF_ZERO;
      rpm_d  = '0;
    end else if (prod_q > ProdW'({RpmW{1'b1}})) begin
      flag_d = RF_SAT;
      rpm_d  = '1;
    end else begin
      flag_d = RF_OK;
      rpm_d  = prod_q[RpmW-1:0];
    end
    for (int w = 0; w < WHEEL_COUNT; w++) begin
      store_d[w] = (job_q.wheel == WheelW'(w)) ? rpm_d : store_q[w];
    end
  end

  for (genvar w = 0; w < MaxWheels; w++) begin : g_lane
    if (w < WHEEL_COUNT) begin : g_used
      assign frame_d[w*RpmW +: RpmW] = store_d[w];
    end else begin : g_unused
      assign frame_d[w*RpmW +: RpmW] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      step_q      <= '0;
      prod_q      <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      wheel_id_q  <= '0;
      period_q    <= '0;
      rpm_q       <= '0;
      frame_q     <= '0;
      flag_q      <= RF_OK;
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        store_q[w] <= '0;
      end
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            job_q  <= job_i;
            rem_q  <= '0;
            quo_q  <= job_i.reload;
            step_q <= '0;
            prod_q <= '0;
            zero_q <= (job_i.period == '0);
            state_q <= (job_i.period == '0) ? S_OUT : S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= fits ? PeriodW'(trial - {1'b0, job_q.period}) : trial[PeriodW-1:0];
          quo_q  <= {quo_q[ReloadW-2:0], fits};
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(ReloadW - 1)) begin
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          prod_q  <= ProdW'(quo_q) * ProdW'(RPM_SCALE);
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold here while the previous result is still waiting
          if (load_out) begin
            wheel_id_q  <= job_q.wheel;
            period_q    <= job_q.period;
            rpm_q       <= rpm_d;
            frame_q     <= frame_d;
            flag_q      <= flag_d;
            for (int w = 0; w < WHEEL_COUNT; w++) begin
              store_q[w] <= store_d[w];
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign wheel_id_o  = wheel_id_q;
  assign period_o    = period_q;
  assign rpm_o       = rpm_q;
  assign frame_o     = frame_q;
  assign flag_o      = flag_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (job_q.period != '0))
    else $error("divider running on a zero period");

  a_quotient_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCALE) |->
      ((33'(quo_q) * 33'(job_q.period)) <= 33'(job_q.reload)) &&
      ((33'(quo_q) * 33'(job_q.period)) + 33'(job_q.period) > 33'(job_q.reload)))
    else $error("quotient out of range after division");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((flag_q == RF_ZERO) == (period_q == '0)))
    else $error("zero-period flag disagrees with period");

  a_flag_rpm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (flag_q == RF_ZERO)) |-> (rpm_q == '0))
    else $error("zero-period result with nonzero rpm");

endmodule

// File: design/capture_period_to_rpm.sv
// Top level of the four-wheel capture-period tachometer.
//
// Input stream (s_axis): one item per completed capture pair of one wheel.
//   tuser carries the wheel channel, tdata the two 16-bit timer snapshots.
// Output stream (m_axis): exactly one result item per input item, in order:
//   wheel id, wrap-corrected period, rpm = RPM_SCALE * (reload / period)
//   saturated to 16 bits, the packed frame of all stored wheel speeds after
//   this update, and a range flag (ok, saturated, zero period).
// Configuration: cfg_we_i writes reload register cfg_index_i (0..3) with
//   cfg_data_i; other indexes are ignored. Write only while the block is idle.
// Flow: an accepted item passes through the queue, 16 steps of the shared
//   restoring divider, a scaling step and the output register. The back end
//   takes no new item until its last result is loaded; its divider yields
//   one quotient bit per cycle. A zero period skips the divider and the
//   scaling step.
// Reset clears the stored speeds to zero, sets every reload to 65535 and
//   empties the queue. When the receiver stalls, the result register holds,
//   the back end waits with its next result and the queue keeps taking
//   items until it is full, then tready drops.
module capture_period_to_rpm #(
  parameter int unsigned WHEEL_COUNT = cptr_pkg::DefWheelCount,
  parameter int unsigned RPM_SCALE   = cptr_pkg::DefRpmScale,
  parameter int unsigned QUEUE_DEPTH = cptr_pkg::DefQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cptr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cptr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // [15:0] first_capture,
                                                       // [31:16] second_capture
  input  logic [1:0]                    s_axis_tuser,  // [1:0] wheel_select
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [103:0]                  m_axis_tdata,  // [16:0] period_ticks, [32:17] wheel_rpm,
                                                       // [96:33] rpm_frame, [103:97] zero
  output logic [3:0]                    m_axis_tuser   // [1:0] wheel_id, [3:2] range_flag
);
  import cptr_pkg::*;

  job_t        front_job, queue_job;
  logic        front_valid, front_ready;
  logic        queue_valid, queue_ready;
  logic [WheelW-1:0]  wheel_id;
  logic [PeriodW-1:0] period;
  logic [RpmW-1:0]    rpm;
  logic [FrameW-1:0]  frame;
  range_flag_e        flag;

  // Classify: look up the channel's reload and form the period
  cptr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .wheel_i     (s_axis_tuser),
    .first_i     (s_axis_tdata[15:0]),
    .second_i    (s_axis_tdata[31:16]),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready),
    .job_o       (front_job)
  );

  // Decouple intake from the divider
  cptr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_job),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_job)
  );

  // Divide, scale, saturate, update the store and hold the result
  cptr_back #(
    .WHEEL_COUNT (WHEEL_COUNT),
    .RPM_SCALE   (RPM_SCALE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (queue_valid),
    .job_ready_o (queue_ready),
    .job_i       (queue_job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .wheel_id_o  (wheel_id),
    .period_o    (period),
    .rpm_o       (rpm),
    .frame_o     (frame),
    .flag_o      (flag)
  );

  assign m_axis_tdata = {7'd0, frame, rpm, period};
  assign m_axis_tuser = {flag, wheel_id};

endmodule
